FILE: rtl/srs_pkg.sv
// Package for the stepper ramp sequencer: field widths, ramp table constants,
// phase encoding, the sequencer state record and the table lookup functions.
// No dependencies.
package srs_pkg;

   localparam int unsigned MS_W         = 8;
   localparam int unsigned TIME_W       = 16;
   localparam int unsigned FREQ_W       = 12;
   localparam int unsigned PHASE_W      = 2;

   localparam int unsigned TABLE_POINTS = 11;
   localparam int unsigned TABLE_LAST   = TABLE_POINTS - 1;

   localparam int unsigned FREQ_BASE    = 180;
   localparam int unsigned FREQ_STEP    = 250;
   localparam int unsigned TIME_STEP    = 20;
   localparam int unsigned HOLD_RESET   = 1000;
   localparam int unsigned FREQ_RESET   = 200;
   localparam int unsigned ELAPSED_MAX  = (1 << TIME_W) - 1;

   typedef enum logic [PHASE_W-1:0] {
      PH_UP   = 2'd0,
      PH_SPIN = 2'd1,
      PH_DOWN = 2'd2
   } phase_type;

   typedef struct packed {
      phase_type         phase;
      logic [TIME_W-1:0] elapsed;
      logic              dir;
      logic [FREQ_W-1:0] freq;
   } srs_state_type;

   // Frequency of table point i: base point first, then evenly spaced steps.
   function automatic logic [FREQ_W-1:0] tbl_freq(input int unsigned i);
      if (i == 0) begin
         return FREQ_W'(FREQ_BASE);
      end
      return FREQ_W'(FREQ_STEP + FREQ_STEP * i);
   endfunction

   // Time of table point i; the last point repeats the time of the one before.
   function automatic int unsigned tbl_time(input int unsigned i);
      int unsigned lim;
      lim = TABLE_POINTS - 2;
      return TIME_STEP * ((i < lim) ? i : lim);
   endfunction

endpackage

FILE: rtl/srs_next.sv
// Next-state logic of the stepper ramp sequencer: saturating time update,
// parallel table compares and phase transitions. Depends on srs_pkg.
module srs_next (
   input  srs_pkg::srs_state_type       cur_state,
   input  logic [srs_pkg::MS_W-1:0]     ms_passed,
   input  logic [srs_pkg::TIME_W-1:0]   spin_hold_ms,
   output srs_pkg::srs_state_type       nxt_state
);
   import srs_pkg::*;

   logic [TIME_W:0]   sum;
   logic [TIME_W-1:0] elapsed_sat;
   logic              up_hit;
   logic [FREQ_W-1:0] up_freq;
   logic              down_hit;
   logic [FREQ_W-1:0] down_freq;
   phase_type         phase_nxt;

   always_comb begin
      sum = {1'b0, cur_state.elapsed} + (TIME_W + 1)'(ms_passed);
      elapsed_sat = sum[TIME_W] ? TIME_W'(ELAPSED_MAX) : sum[TIME_W-1:0];
   end

   // Table compares; walk so the winning point is assigned last.
   always_comb begin
      up_hit    = 1'b0;
      up_freq   = tbl_freq(0);
      down_hit  = 1'b0;
      down_freq = tbl_freq(0);
      for (int i = TABLE_LAST; i >= 1; i--) begin
         if (elapsed_sat < TIME_W'(tbl_time(i))) begin
            up_hit  = 1'b1;
            up_freq = tbl_freq(i - 1);
         end
      end
      for (int k = 0; k < TABLE_LAST; k++) begin
         if (elapsed_sat < TIME_W'(tbl_time(TABLE_LAST) - tbl_time(k))) begin
            down_hit  = 1'b1;
            down_freq = tbl_freq(k + 1);
         end
      end
   end

   // Phase transitions
   always_comb begin
      case (cur_state.phase)
         PH_UP:   phase_nxt = up_hit ? PH_UP : PH_SPIN;
         PH_SPIN: phase_nxt = (elapsed_sat >= spin_hold_ms) ? PH_DOWN : PH_SPIN;
         PH_DOWN: phase_nxt = down_hit ? PH_DOWN : PH_UP;
         default: phase_nxt = cur_state.phase;
      endcase
   end

   // Data updates per phase
   always_comb begin
      nxt_state       = cur_state;
      nxt_state.phase = phase_nxt;
      case (cur_state.phase)
         PH_UP: begin
            nxt_state.elapsed = up_hit ? elapsed_sat : '0;
            nxt_state.freq    = up_hit ? up_freq : tbl_freq(TABLE_LAST);
         end
         PH_SPIN: begin
            nxt_state.elapsed = (phase_nxt == PH_DOWN) ? '0 : elapsed_sat;
         end
         PH_DOWN: begin
            nxt_state.elapsed = down_hit ? elapsed_sat : '0;
            nxt_state.freq    = down_hit ? down_freq : tbl_freq(0);
            nxt_state.dir     = down_hit ? cur_state.dir : ~cur_state.dir;
         end
         default: begin
            nxt_state.elapsed = elapsed_sat;
         end
      endcase
   end

endmodule

FILE: rtl/stepper_ramp_oscillation_sequencer_unit.sv
// Top level of the stepper ramp sequencer: handshakes, input register,
// sequencer state register (which doubles as the result register).
// Depends on srs_pkg and srs_next.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------
//  csr     | in        | csr_valid/csr_ready  | csr_spin_hold_ms[15:0]
//  req     | in        | req_valid/req_ready  | req_ms_passed[7:0]
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_step_freq_hz[11:0], rsp_direction,
//          |           |                      | rsp_phase[1:0]
//
// One transaction per cycle sustained while rsp_ready stays high: a request lands in
// the input register, and the single next-state pass then loads the state/result
// register once the result register is empty or being drained.
// Synchronous active-high reset: spin-up, forward, 200 Hz, hold 1000 ms, no items.
// A stalled result holds the input stage; the input register still takes one
// transaction while a result waits, then req_ready drops.
module stepper_ramp_oscillation_sequencer_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [srs_pkg::TIME_W-1:0]    csr_spin_hold_ms,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [srs_pkg::MS_W-1:0]      req_ms_passed,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [srs_pkg::FREQ_W-1:0]    rsp_step_freq_hz,
   output logic                          rsp_direction,
   output logic [srs_pkg::PHASE_W-1:0]   rsp_phase
);
   import srs_pkg::*;

   logic [TIME_W-1:0] hold_ff;
   logic [TIME_W-1:0] hold_in;
   logic              in_valid_ff;
   logic              in_valid_in;
   logic [MS_W-1:0]   in_ms_ff;
   logic [MS_W-1:0]   in_ms_in;
   logic              out_valid_ff;
   logic              out_valid_in;
   srs_state_type     state_ff;
   srs_state_type     state_in;
   srs_state_type     state_calc;
   logic              out_free;
   logic              advance;
   logic              req_take;

   // Configuration is always taken; the user must write only while idle, the block does not enforce it.
   assign csr_ready = 1'b1;

   // Advance the input stage when the result register is empty or being drained.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   srs_next u_next (
      .cur_state    (state_ff),
      .ms_passed    (in_ms_ff),
      .spin_hold_ms (hold_ff),
      .nxt_state    (state_calc)
   );

   always_comb begin
      hold_in      = (csr_valid && csr_ready) ? csr_spin_hold_ms : hold_ff;
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_ms_in     = req_take ? req_ms_passed : in_ms_ff;
      // Update state only as the result is loaded, so each result is the state
      // after its own transaction.
      state_in     = advance ? state_calc : state_ff;
      out_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff       <= TIME_W'(HOLD_RESET);
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         state_ff.phase   <= PH_UP;
         state_ff.elapsed <= '0;
         state_ff.dir     <= 1'b0;
         state_ff.freq    <= FREQ_W'(FREQ_RESET);
      end else begin
         hold_ff       <= hold_in;
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         state_ff      <= state_in;
      end
   end

   // Payload of the input stage needs no reset.
   always_ff @(posedge clock) begin
      in_ms_ff <= in_ms_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_step_freq_hz = state_ff.freq;
   assign rsp_direction    = state_ff.dir;
   assign rsp_phase        = PHASE_W'(state_ff.phase);

endmodule
